// File: hw/rtl/sode_pkg.sv
package sode_pkg;

    // Input tdata layout, lowest bit first.
    localparam int IN_DATA_W   = 312;
    localparam int ACK_LSB     = 0;
    localparam int CNT_LSB     = 32;
    localparam int CNT_W       = 3;
    localparam int ROOM_LSB    = 35;
    localparam int ROOM_W      = 16;
    localparam int EDGE_LSB    = 51;
    localparam int EDGE_W      = 32;
    localparam int CODE_W      = 40;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIZE,
        S_ROOM,
        S_ERR,
        S_HEAD,
        S_NEXT,
        S_LOAD,
        S_EMIT
    } step_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_START,
        OP_SIZE,
        OP_REWIND,
        OP_LOAD,
        OP_SHIFT
    } op_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_ERR,
        EMIT_HEAD,
        EMIT_DELTA
    } emit_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN,
        COND_DONE,
        COND_FIT,
        COND_OUT,
        COND_BYTE_END
    } cond_t;

    typedef struct packed {
        logic  in_ready;
        op_t   op;
        emit_t emit;
        cond_t cond;
        step_t jump;
        step_t other;
    } ucode_t;

    // Sequencer program: taken conditions go to jump, otherwise to other.
    function automatic ucode_t ucode(step_t s);
        ucode_t w;
        w = '{1'b0, OP_NOP, EMIT_NONE, COND_ALWAYS, S_IDLE, S_IDLE};
        case (s)
            S_IDLE: w = '{1'b1, OP_START,  EMIT_NONE,  COND_IN,       S_SIZE, S_IDLE};
            S_SIZE: w = '{1'b0, OP_SIZE,   EMIT_NONE,  COND_DONE,     S_ROOM, S_SIZE};
            S_ROOM: w = '{1'b0, OP_REWIND, EMIT_NONE,  COND_FIT,      S_HEAD, S_ERR};
            S_ERR:  w = '{1'b0, OP_NOP,    EMIT_ERR,   COND_OUT,      S_IDLE, S_ERR};
            S_HEAD: w = '{1'b0, OP_NOP,    EMIT_HEAD,  COND_OUT,      S_NEXT, S_HEAD};
            S_NEXT: w = '{1'b0, OP_NOP,    EMIT_NONE,  COND_DONE,     S_IDLE, S_LOAD};
            S_LOAD: w = '{1'b0, OP_LOAD,   EMIT_NONE,  COND_ALWAYS,   S_EMIT, S_EMIT};
            S_EMIT: w = '{1'b0, OP_SHIFT,  EMIT_DELTA, COND_BYTE_END, S_NEXT, S_EMIT};
            default: w = '{1'b0, OP_NOP, EMIT_NONE, COND_ALWAYS, S_IDLE, S_IDLE};
        endcase
        return w;
    endfunction

    // Number of bytes the variable-length code of a delta takes.
    function automatic logic [2:0] delta_len(logic [31:0] d);
        if (d < 32'h0000_8000)
            return 3'd2;
        else if (d < 32'h0040_0000)
            return 3'd3;
        else if (d < 32'h2000_0000)
            return 3'd4;
        else
            return 3'd5;
    endfunction

    // The code bytes, first byte in the top bits.
    function automatic logic [CODE_W-1:0] delta_code(logic [31:0] d);
        if (d < 32'h0000_8000)
            return {1'b0, d[14:0], 24'h0};
        else if (d < 32'h0040_0000)
            return {2'b10, d[21:0], 16'h0};
        else if (d < 32'h2000_0000)
            return {3'b110, d[28:0], 8'h0};
        else
            return {8'hff, d};
    endfunction

endpackage

// File: hw/rtl/sack_option_delta_encoder_top.sv
// Channel  | Dir | Signals                  | Contents
// s_axis   | in  | tvalid tready tdata tuser| one SACK option
// m_axis   | out | tvalid tready tdata      | one encoded byte per item,
//          |     | tlast tuser              | tlast on the final byte
//
// An option with c blocks (an unchanged one counts as c = 0) shows its first item,
// the head, after the sizing steps and the room check. Each of the 2c deltas then
// passes through a load step, the steps for its code bytes and a next step, and one more
// step ends the option. rst_n clears the sequencer and the output valid at once.
// A stalled sink holds the output register and the step with a byte to send;
// the next option is taken while the final byte still waits in the register.
module sack_option_delta_encoder_top #(
    parameter int MAX_BLOCKS = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // ack_ref[31:0], block_count[34:32], room_bytes[50:35],
    // start_0, end_0, start_1, end_1, start_2, end_2, start_3, end_3
    // (32 bits each from bit 51 up), zero padding [311:307]
    input  logic [sode_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // unchanged
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_byte[7:0]
    output logic [7:0]                     m_axis_tdata,
    output logic                           m_axis_tlast,
    // no_room
    output logic                           m_axis_tuser
);

    localparam int EDGES = 2 * MAX_BLOCKS;
    localparam int KW    = $clog2(EDGES + 1);
    localparam int IW    = (EDGES > 1) ? $clog2(EDGES) : 1;
    localparam int LEN_W = $clog2(10 * MAX_BLOCKS + 2);

    sode_pkg::step_t   step_reg;
    sode_pkg::step_t   step_next;
    sode_pkg::ucode_t  uc;

    logic [31:0]                   ack_reg;
    logic [31:0]                   base_reg;
    logic [31:0]                   edge_reg [EDGES];
    logic [sode_pkg::CNT_W-1:0]    cnt_reg;
    logic                          same_reg;
    logic [sode_pkg::ROOM_W-1:0]   room_reg;
    logic [LEN_W-1:0]              len_reg;
    logic [KW-1:0]                 k_reg;
    logic [sode_pkg::CODE_W-1:0]   code_reg;
    logic [2:0]                    rem_reg;
    logic                          out_valid_reg;
    logic [7:0]                    out_data_reg;
    logic                          out_last_reg;
    logic                          out_user_reg;

    logic                          in_acc;
    logic [sode_pkg::CNT_W-1:0]    in_cnt;
    logic [sode_pkg::CNT_W-1:0]    in_cnt_sat;
    logic [KW-1:0]                 end_k;
    logic                          done;
    logic [31:0]                   cur_edge;
    logic [31:0]                   delta;
    logic                          out_free;
    logic                          fits;
    logic                          cond_hit;
    logic                          emit_fire;
    logic [7:0]                    emit_data;
    logic                          emit_last;
    logic                          emit_user;

    always_comb
    begin
        uc            = sode_pkg::ucode(step_reg);
        s_axis_tready = uc.in_ready;
        in_acc        = s_axis_tvalid && s_axis_tready;
        in_cnt        = s_axis_tdata[sode_pkg::CNT_LSB +: sode_pkg::CNT_W];
        in_cnt_sat    = (in_cnt > sode_pkg::CNT_W'(MAX_BLOCKS))
                        ? sode_pkg::CNT_W'(MAX_BLOCKS) : in_cnt;
        end_k         = KW'({cnt_reg, 1'b0});
        done          = same_reg || (k_reg == end_k);
        cur_edge      = edge_reg[k_reg[IW-1:0]];
        delta         = cur_edge - base_reg;
        out_free      = !out_valid_reg || m_axis_tready;
        fits          = (sode_pkg::ROOM_W'(len_reg) <= room_reg);

        case (uc.cond)
            sode_pkg::COND_ALWAYS:   cond_hit = 1'b1;
            sode_pkg::COND_IN:       cond_hit = in_acc;
            sode_pkg::COND_DONE:     cond_hit = done;
            sode_pkg::COND_FIT:      cond_hit = fits;
            sode_pkg::COND_OUT:      cond_hit = out_free;
            sode_pkg::COND_BYTE_END: cond_hit = out_free && (rem_reg == 3'd0);
            default:                 cond_hit = 1'b0;
        endcase
        step_next = cond_hit ? uc.jump : uc.other;

        emit_fire = (uc.emit != sode_pkg::EMIT_NONE) && out_free;
        case (uc.emit)
            sode_pkg::EMIT_ERR:
            begin
                emit_data = 8'h00;
                emit_last = 1'b1;
                emit_user = 1'b1;
            end
            sode_pkg::EMIT_HEAD:
            begin
                emit_data = same_reg ? 8'h00 : 8'(cnt_reg);
                emit_last = done;
                emit_user = 1'b0;
            end
            sode_pkg::EMIT_DELTA:
            begin
                emit_data = code_reg[sode_pkg::CODE_W-1 -: 8];
                emit_last = (rem_reg == 3'd0) && (k_reg == end_k);
                emit_user = 1'b0;
            end
            default:
            begin
                emit_data = 8'h00;
                emit_last = 1'b0;
                emit_user = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= sode_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            len_reg       <= '0;
            rem_reg       <= '0;
        end
        else
        begin
            step_reg <= step_next;
            if (emit_fire)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            case (uc.op)
                sode_pkg::OP_START:
                begin
                    if (in_acc)
                    begin
                        k_reg   <= '0;
                        len_reg <= LEN_W'(1);
                    end
                end
                sode_pkg::OP_SIZE:
                begin
                    if (!done)
                    begin
                        k_reg   <= k_reg + KW'(1);
                        len_reg <= len_reg + LEN_W'(sode_pkg::delta_len(delta));
                    end
                end
                sode_pkg::OP_REWIND:
                begin
                    k_reg <= '0;
                end
                sode_pkg::OP_LOAD:
                begin
                    k_reg   <= k_reg + KW'(1);
                    rem_reg <= sode_pkg::delta_len(delta) - 3'd1;
                end
                sode_pkg::OP_SHIFT:
                begin
                    if (out_free && (rem_reg != 3'd0))
                        rem_reg <= rem_reg - 3'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_data_reg <= emit_data;
            out_last_reg <= emit_last;
            out_user_reg <= emit_user;
        end

        case (uc.op)
            sode_pkg::OP_START:
            begin
                if (in_acc)
                begin
                    ack_reg  <= s_axis_tdata[sode_pkg::ACK_LSB +: 32];
                    base_reg <= s_axis_tdata[sode_pkg::ACK_LSB +: 32];
                    cnt_reg  <= in_cnt_sat;
                    same_reg <= s_axis_tuser;
                    room_reg <= s_axis_tdata[sode_pkg::ROOM_LSB +: sode_pkg::ROOM_W];
                    for (int j = 0; j < EDGES; j++)
                    begin
                        edge_reg[j] <=
                            s_axis_tdata[sode_pkg::EDGE_LSB + sode_pkg::EDGE_W * j +: 32];
                    end
                end
            end
            sode_pkg::OP_SIZE:
            begin
                if (!done)
                    base_reg <= cur_edge;
            end
            sode_pkg::OP_REWIND:
            begin
                base_reg <= ack_reg;
            end
            sode_pkg::OP_LOAD:
            begin
                base_reg <= cur_edge;
                code_reg <= sode_pkg::delta_code(delta);
            end
            sode_pkg::OP_SHIFT:
            begin
                if (out_free)
                    code_reg <= code_reg << 8;
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_user_reg;

    // An accepted option keeps the input closed until its encoding is done.
    a_one_option: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_axis_tready)
        else $error("input reopened right after an option was taken");

    // The block index never runs past the number of edges in the option.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != sode_pkg::S_IDLE |-> k_reg <= end_k)
        else $error("block index ran past the option");

    // Bytes are only started once the total length is known to fit.
    a_fit_head: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg == sode_pkg::S_HEAD |-> fits)
        else $error("encoding started although it does not fit");

endmodule
